FILE: sv/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off during rst
`define ARH_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("arh check failed");

// next-cycle implication, sampled on clk, off during rst
`define ARH_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("arh check failed");

`endif

FILE: sv/arh_pkg.sv
`default_nettype none

package arh_pkg;

  localparam int WORD_W    = 64;
  localparam int REG_IDX_W = 2;
  localparam int DIV_CNT_W = $clog2(WORD_W);

  localparam logic [REG_IDX_W-1:0] REG_MODULUS     = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_BASE_WEIGHT = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_EDGE_MODE   = 2'd2;

  typedef struct packed {
    logic signed [31:0] attribute;
    logic signed [31:0] record_id;
    logic signed [31:0] partner_id;
    logic               last_attribute;
  } in_item_t;

  typedef struct packed {
    logic        [63:0] hash;
    logic signed [31:0] out_record_id;
    logic signed [31:0] out_partner_id;
    logic               modulus_error;
  } out_item_t;

  typedef struct packed {
    logic        [63:0] sum;
    logic        [63:0] modulus;
    logic signed [31:0] record_id;
    logic signed [31:0] partner_id;
  } work_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_MUL0,
    F_MUL1,
    F_ACC
  } front_state_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_DIV,
    B_DONE
  } back_state_t;

endpackage

`default_nettype wire

FILE: sv/arh_front.sv
`default_nettype none

module arh_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  output logic            full,
  input  arh_pkg::in_item_t item,
  input  logic [63:0]     modulus,
  input  logic [63:0]     base_weight,
  input  logic            edge_mode,
  input  logic            q_full,
  output logic            q_push,
  output arh_pkg::work_t  q_data
);
  import arh_pkg::*;

  front_state_t state, state_next;
  in_item_t     cur;
  logic [63:0]  sum_acc;
  logic [63:0]  weight;
  logic         in_record;
  logic [63:0]  p_lo;
  logic [31:0]  p_hi;
  logic [63:0]  sq_lo;
  logic [31:0]  sq_x;

  logic               accept;
  logic               advance;
  logic [63:0]        w_cur;
  logic signed [65:0] prod0;
  logic [63:0]        sq0;
  logic [31:0]        prod1;
  logic [31:0]        sqx1;
  logic [63:0]        sum_new;
  logic [63:0]        weight_new;

  assign w_cur = in_record ? weight : base_weight;

  // low and high halves of the weight, registered in F_MUL0 and then F_MUL1
  assign prod0 = $signed({cur.attribute[31], cur.attribute}) * $signed({1'b0, w_cur[31:0]});
  assign sq0   = {32'b0, w_cur[31:0]} * {32'b0, w_cur[31:0]};
  assign prod1 = $unsigned(cur.attribute) * w_cur[63:32];
  assign sqx1  = w_cur[31:0] * w_cur[63:32];

  assign sum_new    = sum_acc + p_lo + {p_hi, 32'b0};
  assign weight_new = sq_lo + {sq_x[30:0], 33'b0};

  always_comb begin
    state_next = state;
    unique case (state)
      F_IDLE: begin
        if (accept) state_next = F_MUL0;
      end
      F_MUL0: state_next = F_MUL1;
      F_MUL1: state_next = F_ACC;
      F_ACC: begin
        if (advance) state_next = accept ? F_MUL0 : F_IDLE;
      end
      default: state_next = F_IDLE;
    endcase
  end

  always_comb begin
    advance = 1'b0;
    full    = 1'b1;
    q_push  = 1'b0;
    unique case (state)
      F_IDLE: full = 1'b0;
      F_ACC: begin
        advance = !(cur.last_attribute && q_full);
        full    = !advance;
        q_push  = cur.last_attribute && !q_full;
      end
      default: begin
        full = 1'b1;
      end
    endcase
  end

  assign accept = push && !full;

  assign q_data.sum        = sum_new;
  assign q_data.modulus    = modulus;
  assign q_data.record_id  = cur.record_id;
  assign q_data.partner_id = edge_mode ? cur.partner_id : 32'sd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= F_IDLE;
      sum_acc   <= '0;
      weight    <= '0;
      in_record <= 1'b0;
    end else begin
      state <= state_next;
      if (state == F_ACC && advance) begin
        if (cur.last_attribute) begin
          sum_acc   <= '0;
          weight    <= '0;
          in_record <= 1'b0;
        end else begin
          sum_acc   <= sum_new;
          weight    <= weight_new;
          in_record <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) cur <= item;
    if (state == F_MUL0) begin
      p_lo  <= prod0[63:0];
      sq_lo <= sq0;
    end
    if (state == F_MUL1) begin
      p_hi <= prod1;
      sq_x <= sqx1;
    end
  end

endmodule

`default_nettype wire

FILE: sv/arh_fifo.sv
`default_nettype none

module arh_fifo #(
  parameter int DEPTH = 2
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr,
  input  arh_pkg::work_t wr_data,
  output logic           is_full,
  input  logic           rd,
  output arh_pkg::work_t rd_data,
  output logic           is_empty
);
  import arh_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  work_t            entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  logic do_wr;
  logic do_rd;

  assign is_full  = (count == CNT_W'(DEPTH));
  assign is_empty = (count == '0);
  assign do_wr    = wr && !is_full;
  assign do_rd    = rd && !is_empty;
  assign rd_data  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (do_rd) rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (do_wr && !do_rd) count <= count + 1'b1;
      else if (do_rd && !do_wr) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) entries[wr_ptr] <= wr_data;
  end

endmodule

`default_nettype wire

FILE: sv/arh_back.sv
`default_nettype none

module arh_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_empty,
  input  arh_pkg::work_t    q_data,
  output logic              q_pop,
  output logic              empty,
  input  logic              pop,
  output arh_pkg::out_item_t result
);
  import arh_pkg::*;

  back_state_t          state, state_next;
  logic [WORD_W-1:0]    rem;
  logic [WORD_W-1:0]    dvd;
  logic [WORD_W-1:0]    divisor;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 err;
  logic signed [31:0]   rec_id;
  logic signed [31:0]   par_id;
  logic                 out_valid;

  logic              take;
  logic              load_out;
  logic              last_step;
  logic [WORD_W:0]   r_sh;
  logic [WORD_W:0]   r_sub;
  logic              fits;
  logic [WORD_W-1:0] rem_step;

  // restoring remainder, one dividend bit per cycle
  assign r_sh     = {rem, dvd[WORD_W-1]};
  assign r_sub    = r_sh - {1'b0, divisor};
  assign fits     = (r_sh >= {1'b0, divisor});
  assign rem_step = fits ? r_sub[WORD_W-1:0] : r_sh[WORD_W-1:0];
  assign last_step = (cnt == DIV_CNT_W'(WORD_W - 1));

  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE: begin
        if (!q_empty) state_next = (q_data.modulus == '0) ? B_DONE : B_DIV;
      end
      B_DIV: begin
        if (last_step) state_next = B_DONE;
      end
      B_DONE: begin
        if (!out_valid || pop) state_next = B_IDLE;
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_comb begin
    take     = 1'b0;
    load_out = 1'b0;
    unique case (state)
      B_IDLE:  take = !q_empty;
      B_DIV:   take = 1'b0;
      B_DONE:  load_out = !out_valid || pop;
      default: take = 1'b0;
    endcase
  end

  assign q_pop = take;
  assign empty = !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      out_valid <= 1'b0;
      cnt       <= '0;
    end else begin
      state <= state_next;
      if (load_out) out_valid <= 1'b1;
      else if (pop) out_valid <= 1'b0;
      if (take) cnt <= '0;
      else if (state == B_DIV) cnt <= cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      rem     <= '0;
      dvd     <= q_data.sum;
      divisor <= q_data.modulus;
      err     <= (q_data.modulus == '0);
      rec_id  <= q_data.record_id;
      par_id  <= q_data.partner_id;
    end else if (state == B_DIV) begin
      rem <= rem_step;
      dvd <= {dvd[WORD_W-2:0], 1'b0};
    end
    if (load_out) begin
      result.hash           <= rem;
      result.out_record_id  <= rec_id;
      result.out_partner_id <= par_id;
      result.modulus_error  <= err;
    end
  end

endmodule

`default_nettype wire

FILE: sv/attribute_record_hash.sv
// channel   | handshake          | payload
// item      | push / full        | arh_pkg::in_item_t
// result    | pop / empty        | arh_pkg::out_item_t
// config    | cfg_write          | cfg_index, cfg_data
//
// the front takes a new item as it finishes the last one: 32x32 products on
// the low and then the high weight half, then an add into the sum and weight
// a record end is reduced by a bit-serial remainder unit, which overlaps
// the next records through a small queue
// rst is synchronous and clears the record state, config, the queue and the waiting result
// full rises while the front multiplies or when a record end meets a full queue
`default_nettype none

module attribute_record_hash #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  arh_pkg::in_item_t   item,
  output logic                empty,
  input  logic                pop,
  output arh_pkg::out_item_t  result,
  input  logic                cfg_write,
  input  logic [1:0]          cfg_index,
  input  logic [63:0]         cfg_data
);
  import arh_pkg::*;

  logic [63:0] modulus;
  logic [63:0] base_weight;
  logic        edge_mode;

  logic  q_push;
  logic  q_full;
  logic  q_pop;
  logic  q_empty;
  work_t q_wr_data;
  work_t q_rd_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus     <= '0;
      base_weight <= '0;
      edge_mode   <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_MODULUS:     modulus     <= cfg_data;
        REG_BASE_WEIGHT: base_weight <= cfg_data;
        REG_EDGE_MODE:   edge_mode   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  arh_front u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .item        (item),
    .modulus     (modulus),
    .base_weight (base_weight),
    .edge_mode   (edge_mode),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_data      (q_wr_data)
  );

  arh_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr       (q_push),
    .wr_data  (q_wr_data),
    .is_full  (q_full),
    .rd       (q_pop),
    .rd_data  (q_rd_data),
    .is_empty (q_empty)
  );

  arh_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_data  (q_rd_data),
    .q_pop   (q_pop),
    .empty   (empty),
    .pop     (pop),
    .result  (result)
  );

endmodule

`default_nettype wire

FILE: sv/arh_checker.sv
`default_nettype none

`include "assert_macros.svh"

module arh_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  logic               full,
  input  logic               empty,
  input  logic               pop,
  input  arh_pkg::out_item_t result
);

  // a waiting result holds until taken
  `ARH_ASSERT_NEXT(a_result_holds, !empty && !pop, !empty && $stable(result))

  // zero modulus always forces a zero hash
  `ARH_ASSERT_NOW(a_err_zero_hash, !empty && result.modulus_error, result.hash == 64'd0)

  // nothing waits right after reset
  `ARH_ASSERT_NOW(a_empty_after_reset, $past(rst), empty)

  // the front is busy multiplying after taking an item
  `ARH_ASSERT_NEXT(a_busy_after_push, push && !full, full)

endmodule

bind attribute_record_hash arh_checker u_arh_checker (.*);

`default_nettype wire
